@@ hdl/mvc_pkg.sv @@
`default_nettype none
package mvc_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int MAX_LINKS    = 1024;
  localparam int NODE_COUNT   = 2 * MAX_VERTICES;
  localparam int ARC_CAP      = 2 * MAX_VERTICES + 4 * MAX_LINKS;
  localparam int LINK_ARCS    = 4 * MAX_LINKS;
  localparam int VX_W         = $clog2(MAX_VERTICES);
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int ARC_W        = $clog2(ARC_CAP);
  localparam int RES_W        = 30;
  localparam int LVL_W        = NODE_W + 1;
  localparam int CNT_W        = NODE_W + 1;

  localparam logic [ARC_W-1:0] NO_ARC  = '1;
  localparam logic [RES_W-1:0] BIG_CAP = RES_W'(1000000000);

  // Configuration register indexes.
  localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE       = 2'd1;
  localparam logic [1:0] REG_SINK         = 2'd2;

  // One arc of the residual graph as stored in the arc memory.
  typedef struct packed {
    logic [NODE_W-1:0] target;
    logic [RES_W-1:0]  residual;
    logic [ARC_W-1:0]  next;
  } arc_t;

  typedef enum logic [5:0] {
    S_IDLE, S_AR_RD, S_AR_WR, S_START,
    S_AD_RD, S_AD_HD, S_AD_ARC, S_AD_CHK,
    S_SW, S_LS_INIT, S_LS_POP, S_LS_POPW, S_LS_HD, S_LS_ARC, S_LS_ARCW, S_LS_TG,
    S_LS_END, S_LS_ENDW,
    S_BF_TOP, S_BF_CUR, S_BF_ARC, S_BF_LV, S_BF_POPW, S_BF_POPA, S_BF_POPB,
    S_AU_MIN, S_AU_MINW, S_AU_MINC, S_AU_UPD, S_AU_UW, S_AU_UA, S_AU_UB,
    S_DONE
  } state_t;

  // Node numbering: in-nodes first, then out-nodes.
  function automatic logic [NODE_W-1:0] in_node(input logic [7:0] v);
    logic [7:0] m;
    m = v - 8'd1;
    return {1'b0, m[VX_W-1:0]};
  endfunction

  function automatic logic [NODE_W-1:0] out_node(input logic [7:0] v);
    logic [7:0] m;
    m = v - 8'd1;
    return {1'b1, m[VX_W-1:0]};
  endfunction

endpackage
`default_nettype wire

@@ hdl/mvc_ram.sv @@
`default_nettype none
module mvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port that holds while not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/min_vertex_cut_max_flow.sv @@
// Each link word that passes the checks gets four arcs, each of a head read and an arc write.
// After the last link the flow search runs from memory: splitting writes two
// arcs per vertex, and each level search sweeps every node and then walks a
// queue, scanning arcs. The result word is registered in S_DONE.
// Reset is synchronous; it empties the arc lists at once through valid bits.
`default_nettype none
module min_vertex_cut_max_flow (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_first_end,
  input  wire logic [7:0] in_second_end,
  input  wire logic       in_last_link,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_cut_size,
  output logic            out_no_cut
);
  import mvc_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0] vcount_r, src_vx_r, snk_vx_r;
  logic [7:0] ea_r, ea_nxt, eb_r, eb_nxt;
  logic last_r, last_nxt, split_r, split_nxt;
  logic [1:0] j_r, j_nxt;
  logic [7:0] vx_r, vx_nxt;
  logic [ARC_W-1:0] count_r, count_nxt, a_r, a_nxt;
  logic [NODE_W-1:0] nd_r, nd_nxt;
  logic [LVL_W-1:0] lvl_nd_r, lvl_nd_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt, wr_r, wr_nxt, depth_r, depth_nxt, k_r, k_nxt;
  logic [RES_W-1:0] lim_r, lim_nxt;
  logic [7:0] flow_r, flow_nxt;
  logic none_r, none_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_cut_r, out_cut_nxt;
  logic out_none_r, out_none_nxt;

  // Head list store with one valid bit per node.
  logic [ARC_W-1:0] head_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] hv_r;
  logic head_re, head_we, head_clr;
  logic [NODE_W-1:0] head_ra, head_wa;
  logic [ARC_W-1:0] head_q;
  logic hv_q;
  logic [ARC_W-1:0] head_val;

  // Ports of the other memories.
  logic arc_we, arc_re, lvl_we, lvl_re, cur_we, cur_re, q_we, q_re, stk_we, stk_re;
  logic [ARC_W-1:0] arc_wa, arc_ra;
  arc_t arc_wd, arc_q;
  logic [NODE_W-1:0] lvl_wa, lvl_ra, cur_wa, cur_ra, q_wa, q_ra, stk_wa, stk_ra;
  logic [LVL_W-1:0] lvl_wd, lvl_q;
  logic [ARC_W-1:0] cur_wd, cur_q, stk_wd, stk_q;
  logic [NODE_W-1:0] q_wd, q_q;

  logic [NODE_W-1:0] gen_from, gen_to, src_nd, snk_nd;
  logic [RES_W-1:0] gen_cap;
  logic [7:0] nv;
  logic link_ok;
  logic [ARC_W:0] count_ext;

  mvc_ram #(.WIDTH($bits(arc_t)), .DEPTH(ARC_CAP)) u_arc (
    .clk(clk), .we(arc_we), .waddr(arc_wa), .wdata(arc_wd),
    .re(arc_re), .raddr(arc_ra), .rdata(arc_q)
  );
  mvc_ram #(.WIDTH(LVL_W), .DEPTH(NODE_COUNT)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
    .re(lvl_re), .raddr(lvl_ra), .rdata(lvl_q)
  );
  mvc_ram #(.WIDTH(ARC_W), .DEPTH(NODE_COUNT)) u_cur (
    .clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd),
    .re(cur_re), .raddr(cur_ra), .rdata(cur_q)
  );
  mvc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .re(q_re), .raddr(q_ra), .rdata(q_q)
  );
  mvc_ram #(.WIDTH(ARC_W), .DEPTH(NODE_COUNT)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .re(stk_re), .raddr(stk_ra), .rdata(stk_q)
  );

  // Head memory body and registered read.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= count_r;
    end
    if (head_re) begin
      head_q <= head_mem[head_ra];
      hv_q   <= hv_r[head_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || head_clr) begin
      hv_r <= '0;
    end else if (head_we) begin
      hv_r[head_wa] <= 1'b1;
    end
  end

  assign head_val = hv_q ? head_q : NO_ARC;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 8'd2;
      src_vx_r <= 8'd1;
      snk_vx_r <= 8'd2;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT: vcount_r <= cfg_wr_data;
        REG_SOURCE:       src_vx_r <= cfg_wr_data;
        REG_SINK:         snk_vx_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign nv     = (vcount_r > 8'(MAX_VERTICES)) ? 8'(MAX_VERTICES) : vcount_r;
  assign src_nd = in_node(src_vx_r);
  assign snk_nd = in_node(snk_vx_r);
  assign count_ext = {1'b0, count_r} + (ARC_W+1)'(4);
  assign link_ok = (in_first_end >= 8'd1) && (in_first_end <= 8'(MAX_VERTICES)) &&
                   (in_second_end >= 8'd1) && (in_second_end <= 8'(MAX_VERTICES)) &&
                   (count_ext <= (ARC_W+1)'(LINK_ARCS));

  // Arc generator: link arcs and vertex split arcs with their reverses.
  always_comb begin
    gen_from = '0;
    gen_to   = '0;
    gen_cap  = '0;
    if (split_r) begin
      if (!j_r[0]) begin
        gen_from = in_node(vx_r);
        gen_to   = out_node(vx_r);
        gen_cap  = (vx_r == src_vx_r || vx_r == snk_vx_r) ? BIG_CAP : RES_W'(1);
      end else begin
        gen_from = out_node(vx_r);
        gen_to   = in_node(vx_r);
      end
    end else begin
      case (j_r)
        2'd0: begin
          gen_from = out_node(ea_r);
          gen_to   = in_node(eb_r);
          gen_cap  = BIG_CAP;
        end
        2'd1: begin
          gen_from = in_node(eb_r);
          gen_to   = out_node(ea_r);
        end
        2'd2: begin
          gen_from = out_node(eb_r);
          gen_to   = in_node(ea_r);
          gen_cap  = BIG_CAP;
        end
        default: begin
          gen_from = in_node(ea_r);
          gen_to   = out_node(eb_r);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ea_r      <= ea_nxt;
    eb_r      <= eb_nxt;
    last_r    <= last_nxt;
    split_r   <= split_nxt;
    j_r       <= j_nxt;
    vx_r      <= vx_nxt;
    a_r       <= a_nxt;
    nd_r      <= nd_nxt;
    lvl_nd_r  <= lvl_nd_nxt;
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    depth_r   <= depth_nxt;
    k_r       <= k_nxt;
    lim_r     <= lim_nxt;
    flow_r    <= flow_nxt;
    none_r    <= none_nxt;
    out_cut_r <= out_cut_nxt;
    out_none_r <= out_none_nxt;
  end

  // Sequencer: link insertion, splitting, adjacency check, level search, blocking flow, augment, result.
  always_comb begin
    state_nxt = state_r;
    ea_nxt = ea_r; eb_nxt = eb_r; last_nxt = last_r; split_nxt = split_r;
    j_nxt = j_r; vx_nxt = vx_r; count_nxt = count_r; a_nxt = a_r; nd_nxt = nd_r;
    lvl_nd_nxt = lvl_nd_r; rd_nxt = rd_r; wr_nxt = wr_r; depth_nxt = depth_r;
    k_nxt = k_r; lim_nxt = lim_r; flow_nxt = flow_r; none_nxt = none_r;
    out_cut_nxt = out_cut_r; out_none_nxt = out_none_r;
    out_valid_nxt = out_valid_r && out_stall;

    head_re = 1'b0; head_ra = '0; head_we = 1'b0; head_wa = gen_from; head_clr = 1'b0;
    arc_re = 1'b0; arc_ra = '0; arc_we = 1'b0; arc_wa = '0; arc_wd = arc_q;
    lvl_re = 1'b0; lvl_ra = '0; lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0;
    cur_re = 1'b0; cur_ra = '0; cur_we = 1'b0; cur_wa = '0; cur_wd = '0;
    q_re = 1'b0; q_ra = '0; q_we = 1'b0; q_wa = '0; q_wd = '0;
    stk_re = 1'b0; stk_ra = '0; stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
    in_stall = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        in_stall = out_valid_r && in_last_link;
        if (in_valid && !in_stall) begin
          ea_nxt = in_first_end;
          eb_nxt = in_second_end;
          last_nxt = in_last_link;
          split_nxt = 1'b0;
          j_nxt = 2'd0;
          if (link_ok) begin
            state_nxt = S_AR_RD;
          end else if (in_last_link) begin
            state_nxt = S_START;
          end
        end
      end
      S_AR_RD: begin
        head_re = 1'b1;
        head_ra = gen_from;
        state_nxt = S_AR_WR;
      end
      S_AR_WR: begin
        arc_we = 1'b1;
        arc_wa = count_r;
        arc_wd = '{target: gen_to, residual: gen_cap, next: head_val};
        head_we = 1'b1;
        count_nxt = count_r + ARC_W'(1);
        state_nxt = S_AR_RD;
        j_nxt = j_r + 2'd1;
        if (split_r) begin
          if (j_r[0]) begin
            j_nxt = 2'd0;
            if (vx_r == nv) begin
              state_nxt = S_AD_RD;
            end else begin
              vx_nxt = vx_r + 8'd1;
            end
          end
        end else if (j_r == 2'd3) begin
          state_nxt = last_r ? S_START : S_IDLE;
        end
      end
      S_START: begin
        flow_nxt = '0;
        none_nxt = 1'b0;
        if (src_vx_r < 8'd1 || src_vx_r > nv || snk_vx_r < 8'd1 || snk_vx_r > nv) begin
          state_nxt = S_DONE;
        end else if (src_vx_r == snk_vx_r) begin
          none_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          split_nxt = 1'b1;
          vx_nxt = 8'd1;
          j_nxt = 2'd0;
          state_nxt = S_AR_RD;
        end
      end
      // Adjacency check over the out-node of the source.
      S_AD_RD: begin
        head_re = 1'b1;
        head_ra = out_node(src_vx_r);
        state_nxt = S_AD_HD;
      end
      S_AD_HD: begin
        a_nxt = head_val;
        state_nxt = S_AD_ARC;
      end
      S_AD_ARC: begin
        if (a_r == NO_ARC) begin
          k_nxt = '0;
          state_nxt = S_SW;
        end else begin
          arc_re = 1'b1;
          arc_ra = a_r;
          state_nxt = S_AD_CHK;
        end
      end
      S_AD_CHK: begin
        if (!a_r[0] && arc_q.target == snk_nd) begin
          none_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          a_nxt = arc_q.next;
          state_nxt = S_AD_ARC;
        end
      end
      // Level search: sweep levels and current arcs, then a queue walk.
      S_SW: begin
        head_re = 1'b1;
        head_ra = k_r[NODE_W-1:0];
        if (k_r != '0) begin
          lvl_we = 1'b1;
          lvl_wa = NODE_W'(k_r - CNT_W'(1));
          cur_we = 1'b1;
          cur_wa = NODE_W'(k_r - CNT_W'(1));
          cur_wd = head_val;
        end
        if (k_r == CNT_W'(NODE_COUNT)) begin
          state_nxt = S_LS_INIT;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      S_LS_INIT: begin
        lvl_we = 1'b1;
        lvl_wa = src_nd;
        lvl_wd = LVL_W'(1);
        q_we = 1'b1;
        q_wa = '0;
        q_wd = src_nd;
        rd_nxt = '0;
        wr_nxt = CNT_W'(1);
        state_nxt = S_LS_POP;
      end
      S_LS_POP: begin
        if (rd_r == wr_r) begin
          state_nxt = S_LS_END;
        end else begin
          q_re = 1'b1;
          q_ra = rd_r[NODE_W-1:0];
          rd_nxt = rd_r + CNT_W'(1);
          state_nxt = S_LS_POPW;
        end
      end
      S_LS_POPW: begin
        nd_nxt = q_q;
        head_re = 1'b1;
        head_ra = q_q;
        lvl_re = 1'b1;
        lvl_ra = q_q;
        state_nxt = S_LS_HD;
      end
      S_LS_HD: begin
        a_nxt = head_val;
        lvl_nd_nxt = lvl_q;
        state_nxt = S_LS_ARC;
      end
      S_LS_ARC: begin
        if (a_r == NO_ARC) begin
          state_nxt = S_LS_POP;
        end else begin
          arc_re = 1'b1;
          arc_ra = a_r;
          state_nxt = S_LS_ARCW;
        end
      end
      S_LS_ARCW: begin
        lvl_re = 1'b1;
        lvl_ra = arc_q.target;
        state_nxt = S_LS_TG;
      end
      S_LS_TG: begin
        if (arc_q.residual != '0 && lvl_q == '0) begin
          lvl_we = 1'b1;
          lvl_wa = arc_q.target;
          lvl_wd = lvl_nd_r + LVL_W'(1);
          if (!wr_r[CNT_W-1]) begin
            q_we = 1'b1;
            q_wa = wr_r[NODE_W-1:0];
            q_wd = arc_q.target;
            wr_nxt = wr_r + CNT_W'(1);
          end
        end
        a_nxt = arc_q.next;
        state_nxt = S_LS_ARC;
      end
      S_LS_END: begin
        lvl_re = 1'b1;
        lvl_ra = snk_nd;
        state_nxt = S_LS_ENDW;
      end
      S_LS_ENDW: begin
        if (lvl_q != '0) begin
          depth_nxt = '0;
          nd_nxt = src_nd;
          state_nxt = S_BF_TOP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // Blocking flow with current-arc pointers and a path stack.
      S_BF_TOP: begin
        if (nd_r == snk_nd) begin
          lim_nxt = BIG_CAP;
          k_nxt = '0;
          state_nxt = S_AU_MIN;
        end else begin
          cur_re = 1'b1;
          cur_ra = nd_r;
          lvl_re = 1'b1;
          lvl_ra = nd_r;
          state_nxt = S_BF_CUR;
        end
      end
      S_BF_CUR: begin
        a_nxt = cur_q;
        lvl_nd_nxt = lvl_q;
        if (cur_q == NO_ARC) begin
          if (depth_r == '0) begin
            k_nxt = '0;
            state_nxt = S_SW;
          end else begin
            depth_nxt = depth_r - CNT_W'(1);
            stk_re = 1'b1;
            stk_ra = NODE_W'(depth_r - CNT_W'(1));
            state_nxt = S_BF_POPW;
          end
        end else begin
          arc_re = 1'b1;
          arc_ra = cur_q;
          state_nxt = S_BF_ARC;
        end
      end
      S_BF_ARC: begin
        lvl_re = 1'b1;
        lvl_ra = arc_q.target;
        state_nxt = S_BF_LV;
      end
      S_BF_LV: begin
        if (arc_q.residual != '0 && lvl_q == lvl_nd_r + LVL_W'(1) && !depth_r[CNT_W-1]) begin
          stk_we = 1'b1;
          stk_wa = depth_r[NODE_W-1:0];
          stk_wd = a_r;
          depth_nxt = depth_r + CNT_W'(1);
          nd_nxt = arc_q.target;
        end else begin
          cur_we = 1'b1;
          cur_wa = nd_r;
          cur_wd = arc_q.next;
        end
        state_nxt = S_BF_TOP;
      end
      S_BF_POPW: begin
        a_nxt = stk_q;
        arc_re = 1'b1;
        arc_ra = stk_q ^ ARC_W'(1);
        state_nxt = S_BF_POPA;
      end
      S_BF_POPA: begin
        nd_nxt = arc_q.target;
        arc_re = 1'b1;
        arc_ra = a_r;
        state_nxt = S_BF_POPB;
      end
      S_BF_POPB: begin
        cur_we = 1'b1;
        cur_wa = nd_r;
        cur_wd = arc_q.next;
        state_nxt = S_BF_TOP;
      end
      // Augment: bottleneck over the path, then update both directions.
      S_AU_MIN: begin
        if (k_r == depth_r) begin
          k_nxt = '0;
          state_nxt = S_AU_UPD;
        end else begin
          stk_re = 1'b1;
          stk_ra = k_r[NODE_W-1:0];
          state_nxt = S_AU_MINW;
        end
      end
      S_AU_MINW: begin
        arc_re = 1'b1;
        arc_ra = stk_q;
        state_nxt = S_AU_MINC;
      end
      S_AU_MINC: begin
        if (arc_q.residual < lim_r) begin
          lim_nxt = arc_q.residual;
        end
        k_nxt = k_r + CNT_W'(1);
        state_nxt = S_AU_MIN;
      end
      S_AU_UPD: begin
        if (k_r == depth_r) begin
          flow_nxt = flow_r + lim_r[7:0];
          depth_nxt = '0;
          nd_nxt = src_nd;
          state_nxt = S_BF_TOP;
        end else begin
          stk_re = 1'b1;
          stk_ra = k_r[NODE_W-1:0];
          state_nxt = S_AU_UW;
        end
      end
      S_AU_UW: begin
        a_nxt = stk_q;
        arc_re = 1'b1;
        arc_ra = stk_q;
        state_nxt = S_AU_UA;
      end
      S_AU_UA: begin
        arc_we = 1'b1;
        arc_wa = a_r;
        arc_wd = arc_q;
        arc_wd.residual = arc_q.residual - lim_r;
        arc_re = 1'b1;
        arc_ra = a_r ^ ARC_W'(1);
        state_nxt = S_AU_UB;
      end
      S_AU_UB: begin
        arc_we = 1'b1;
        arc_wa = a_r ^ ARC_W'(1);
        arc_wd = arc_q;
        arc_wd.residual = arc_q.residual + lim_r;
        k_nxt = k_r + CNT_W'(1);
        state_nxt = S_AU_UPD;
      end
      // Result word and clearing of the graph.
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_cut_nxt = none_r ? 8'd0 : flow_r;
        out_none_nxt = none_r;
        head_clr = 1'b1;
        count_nxt = '0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_cut_size = out_cut_r;
  assign out_no_cut   = out_none_r;

endmodule
`default_nettype wire
